>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked and held off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/bia_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap index allocator package
// Request and response words, operation and status codes, word search.
// ----------------------------------------------------------------------------
`default_nettype none

package bia_pkg;

  localparam int WordW = 32;
  localparam int BitW  = 5;
  localparam int IdxW  = 10;
  localparam int SizeW = 11;

  typedef enum logic [1:0] {
    OP_ALLOC_FIRST = 2'd0,
    OP_ALLOC_FROM  = 2'd1,
    OP_CLAIM       = 2'd2,
    OP_RELEASE     = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NO_FREE = 3'd1,
    ST_TAKEN   = 3'd2,
    ST_NOT_SET = 3'd3,
    ST_RANGE   = 3'd4
  } status_t;

  typedef struct packed {
    op_t              operation;
    logic [IdxW-1:0]  index;
  } req_t;

  typedef struct packed {
    status_t          status;
    logic [IdxW-1:0]  granted_index;
  } rsp_t;

  typedef struct packed {
    logic             found;
    logic [BitW-1:0]  pos;
  } find_t;

  // lowest set bit of a word
  function automatic find_t first_set(input logic [WordW-1:0] v);
    find_t f;
    f.found = 1'b0;
    f.pos   = '0;
    for (int i = WordW - 1; i >= 0; i--) begin
      if (v[i]) begin
        f.found = 1'b1;
        f.pos   = BitW'(i);
      end
    end
    return f;
  endfunction

endpackage

`default_nettype wire

>>> hdl/bia_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bia_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic                                  re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> hdl/bitmap_index_allocator.sv
// ----------------------------------------------------------------------------
// Bitmap index allocator
// Used-index bitmap in RAM, 32 bits per word, with word-wise free search.
// ----------------------------------------------------------------------------
// Claim and release read their map word, update the bit in scan and respond from done;
// out of range, a request goes from idle straight to done, as does an allocate with an
// empty search range. Allocate reads one RAM word per cycle in scan until a free bit is
// found or the last word is read. Requests stall until the response is loaded.
// Reset: size returns to 1024; a clearing pass then writes zero to every RAM word,
// one per cycle (MAX_ENTRIES/32 rounded up), and requests stall until it ends.
`default_nettype none
`include "assert_macros.svh"

module bitmap_index_allocator #(
  parameter int MAX_ENTRIES = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [bia_pkg::SizeW-1:0] cfg_data,
  input  wire logic                     req_valid,
  output logic                          req_stall,
  input  wire bia_pkg::req_t            req,
  output logic                          rsp_valid,
  input  wire logic                     rsp_stall,
  output bia_pkg::rsp_t                 rsp
);

  localparam int NumWords = (MAX_ENTRIES + bia_pkg::WordW - 1) / bia_pkg::WordW;
  localparam int AW       = NumWords > 1 ? $clog2(NumWords) : 1;
  localparam int PW       = AW + bia_pkg::BitW;
  localparam int CW       = (PW > bia_pkg::SizeW ? PW : bia_pkg::SizeW) + 1;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_SCAN  = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t                      state;
  logic [AW-1:0]               clr_addr;
  logic [bia_pkg::SizeW-1:0]   active_size;
  bia_pkg::op_t                op;
  logic [bia_pkg::BitW-1:0]    bit_sel;
  logic [AW-1:0]               word;
  logic                        first;
  bia_pkg::rsp_t               res;

  logic [bia_pkg::SizeW-1:0]   size;
  logic [CW-1:0]               size_ext;
  logic [bia_pkg::IdxW-1:0]    req_start;
  logic                        req_in_range;
  logic                        accept;
  logic                        is_alloc;
  logic [CW-1:0]               base_ext;
  logic [CW-1:0]               rem;
  logic [bia_pkg::WordW-1:0]   hi_mask;
  logic [bia_pkg::WordW-1:0]   lo_mask;
  logic [bia_pkg::WordW-1:0]   free_bits;
  bia_pkg::find_t              hit;
  logic                        last_word;
  logic                        cur_bit;
  logic [bia_pkg::WordW-1:0]   bit_onehot;
  logic [bia_pkg::WordW-1:0]   hit_onehot;
  logic                        scan_next;
  logic                        res_load;

  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [bia_pkg::WordW-1:0]   ram_wdata;
  logic                        ram_re;
  logic [AW-1:0]               ram_raddr;
  logic [bia_pkg::WordW-1:0]   ram_rdata;

  assign cfg_ready = 1'b1;

  assign size = (32'(active_size) < 32'(MAX_ENTRIES)) ? active_size
                                                      : bia_pkg::SizeW'(MAX_ENTRIES);
  assign size_ext = CW'(size);

  assign req_stall    = (state != S_IDLE);
  assign accept       = req_valid && !req_stall;
  assign req_start    = (req.operation == bia_pkg::OP_ALLOC_FIRST) ? '0 : req.index;
  assign req_in_range = CW'(req_start) < size_ext;

  assign is_alloc   = (op == bia_pkg::OP_ALLOC_FIRST) || (op == bia_pkg::OP_ALLOC_FROM);
  assign base_ext   = CW'({word, {bia_pkg::BitW{1'b0}}});
  assign rem        = size_ext - base_ext;
  assign hi_mask    = (rem >= CW'(bia_pkg::WordW)) ? '1
                    : (bia_pkg::WordW'(1) << rem[bia_pkg::BitW-1:0]) - bia_pkg::WordW'(1);
  assign lo_mask    = first ? ({bia_pkg::WordW{1'b1}} << bit_sel) : '1;
  assign free_bits  = ~ram_rdata & hi_mask & lo_mask;
  assign hit        = bia_pkg::first_set(free_bits);
  assign last_word  = (base_ext + CW'(bia_pkg::WordW)) >= size_ext;
  assign cur_bit    = ram_rdata[bit_sel];
  assign bit_onehot = bia_pkg::WordW'(1) << bit_sel;
  assign hit_onehot = bia_pkg::WordW'(1) << hit.pos;
  assign scan_next  = (state == S_SCAN) && is_alloc && !hit.found && !last_word;
  assign res_load   = (state == S_DONE) && (!rsp_valid || !rsp_stall);

  always_comb begin
    ram_re    = (accept && req_in_range) || scan_next;
    ram_raddr = (state == S_SCAN) ? AW'(word + AW'(1)) : AW'(req_start >> bia_pkg::BitW);
    ram_we    = 1'b0;
    ram_waddr = word;
    ram_wdata = ram_rdata;
    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
      end
      S_SCAN: begin
        unique case (op)
          bia_pkg::OP_ALLOC_FIRST, bia_pkg::OP_ALLOC_FROM: begin
            ram_we    = hit.found;
            ram_wdata = ram_rdata | hit_onehot;
          end
          bia_pkg::OP_CLAIM: begin
            ram_we    = !cur_bit;
            ram_wdata = ram_rdata | bit_onehot;
          end
          bia_pkg::OP_RELEASE: begin
            ram_we    = cur_bit;
            ram_wdata = ram_rdata & ~bit_onehot;
          end
          default: begin
            ram_we = 1'b0;
          end
        endcase
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  bia_ram #(
    .WIDTH (bia_pkg::WordW),
    .DEPTH (NumWords)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      active_size <= bia_pkg::SizeW'(1024);
      rsp_valid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        active_size <= cfg_data;
      end
      if (res_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= AW'(clr_addr + AW'(1));
          if (clr_addr == AW'(NumWords - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state <= req_in_range ? S_SCAN : S_DONE;
          end
        end
        S_SCAN: begin
          if (!scan_next) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      rsp <= res;
    end
    if (accept) begin
      op      <= req.operation;
      bit_sel <= req_start[bia_pkg::BitW-1:0];
      word    <= AW'(req_start >> bia_pkg::BitW);
      first   <= 1'b1;
      res     <= '{status: ((req.operation == bia_pkg::OP_ALLOC_FIRST) ||
                            (req.operation == bia_pkg::OP_ALLOC_FROM))
                           ? bia_pkg::ST_NO_FREE : bia_pkg::ST_RANGE,
                   granted_index: '0};
    end else if (state == S_SCAN) begin
      if (scan_next) begin
        word  <= AW'(word + AW'(1));
        first <= 1'b0;
      end
      unique case (op)
        bia_pkg::OP_ALLOC_FIRST, bia_pkg::OP_ALLOC_FROM: begin
          res <= hit.found
               ? '{status: bia_pkg::ST_OK,
                   granted_index: bia_pkg::IdxW'({word, hit.pos})}
               : '{status: bia_pkg::ST_NO_FREE, granted_index: '0};
        end
        bia_pkg::OP_CLAIM: begin
          res <= '{status: cur_bit ? bia_pkg::ST_TAKEN : bia_pkg::ST_OK,
                   granted_index: '0};
        end
        bia_pkg::OP_RELEASE: begin
          res <= '{status: cur_bit ? bia_pkg::ST_OK : bia_pkg::ST_NOT_SET,
                   granted_index: '0};
        end
        default: begin
          res <= res;
        end
      endcase
    end
  end

  `ASSERT_NEXT(a_one_in_flight, clk, rst, accept, req_stall, "request taken while busy")
  `ASSERT_NOW(a_write_phase, clk, rst, ram_we, (state == S_CLEAR) || (state == S_SCAN),
    "map written outside clear or scan")
  `ASSERT_NOW(a_single_bit, clk, rst, ram_we && (state == S_SCAN),
    $countones(ram_wdata ^ ram_rdata) == 1, "update changes other than one bit")
  `ASSERT_NOW(a_grant_zero, clk, rst, rsp_valid && (rsp.status != bia_pkg::ST_OK),
    rsp.granted_index == '0, "index returned with failing status")

endmodule

`default_nettype wire
